// ----- design/qwcg_pkg.sv -----
// Package with shared constants, types and Pauli helper functions for the grouper.
package qwcg_pkg;

  localparam int MAX_QUBITS  = 16;
  localparam int MAX_GROUPS  = 16;
  localparam int WORD_W      = 32;
  localparam int GIDX_W      = (MAX_GROUPS > 1) ? $clog2(MAX_GROUPS) : 1;
  localparam int GCNT_W      = $clog2(MAX_GROUPS + 1);
  localparam int NQ_W        = 5;
  localparam int OUT_IDX_W   = 4;
  localparam int OUT_CNT_W   = 5;
  localparam int OUT_TDATA_W = 48;
  localparam int OUT_PAD_W   = OUT_TDATA_W - OUT_IDX_W - WORD_W - OUT_CNT_W;
  localparam int CFG_DATA_W  = 5;

  localparam logic [WORD_W-1:0] LOW_BITS = 32'h5555_5555;

  localparam logic       ACT_CLEAR        = 1'b0;
  localparam logic       ACT_PLACE        = 1'b1;
  localparam logic       CFG_NUM_QUBITS   = 1'b0;
  localparam logic       CFG_GROUP_ENABLE = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic              valid;
    logic              found;
    logic              is_new;
    logic [GIDX_W-1:0] idx;
    logic [WORD_W-1:0] term;
    logic [WORD_W-1:0] basis;
  } token_t;

  typedef struct packed {
    logic [OUT_IDX_W-1:0] gidx;
    logic                 is_new;
    logic                 is_id;
    logic                 ovf;
    logic [WORD_W-1:0]    basis;
    logic [OUT_CNT_W-1:0] groups;
  } result_t;

  function automatic logic [WORD_W-1:0] active_qubits(input logic [WORD_W-1:0] s);
    active_qubits = (s | (s >> 1)) & LOW_BITS;
  endfunction

  function automatic logic agrees(input logic [WORD_W-1:0] term,
                                  input logic [WORD_W-1:0] basis);
    logic [WORD_W-1:0] both;
    logic [WORD_W-1:0] diff;
    both   = active_qubits(term) & active_qubits(basis);
    diff   = active_qubits(term ^ basis);
    agrees = ((both & diff) == '0);
  endfunction

  function automatic logic [WORD_W-1:0] merge(input logic [WORD_W-1:0] basis,
                                              input logic [WORD_W-1:0] term);
    logic [WORD_W-1:0] m;
    m     = active_qubits(term) | (active_qubits(term) << 1);
    merge = (basis & ~m) | (term & m);
  endfunction

  function automatic logic [WORD_W-1:0] qubit_mask(input logic [NQ_W-1:0] n);
    logic [NQ_W-1:0] n_sat;
    n_sat = (int'(n) > MAX_QUBITS) ? NQ_W'(MAX_QUBITS) : n;
    for (int q = 0; q < WORD_W / 2; q++) begin
      qubit_mask[2*q +: 2] = (q < int'(n_sat)) ? 2'b11 : 2'b00;
    end
  endfunction

endpackage

// ----- design/qubitwise_commuting_grouper.sv -----
// Top level of the qubit-wise commuting grouper: control, group count and the cell chain.
// A placed term travels down a row of MAX_GROUPS cells, one cell per cycle; the first
// stored group it agrees with takes it while group merging is enabled, otherwise the
// cell just past the last stored group opens a new group, or overflow is reported when
// all groups are in use. The result of a placing request is held in a pending register
// when it leaves the cell chain and is then loaded into the output register; clear and
// all-identity requests skip the cell chain. Loading the output register waits while an
// earlier result there has not been taken. One request is in work at a time, and the next
// request is accepted from the cycle after the result is loaded, while that result may
// still wait in the output register. No clearing pass runs after reset.
module qubitwise_commuting_grouper (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  input  logic [qwcg_pkg::WORD_W-1:0]          in_tdata,   // [31:0] pauli_string
  input  logic                                 in_tuser,   // [0] action
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  output logic [qwcg_pkg::OUT_TDATA_W-1:0]     out_tdata,  // [3:0] group_index,
                                                           // [35:4] merged_basis,
                                                           // [40:36] groups_in_use
  output logic [2:0]                           out_tuser,  // [0] is_new_group,
                                                           // [1] is_identity, [2] overflow
  input  logic                                 cfg_wen,
  input  logic                                 cfg_index,
  input  logic [qwcg_pkg::CFG_DATA_W-1:0]      cfg_wdata
);

  qwcg_pkg::state_t              state_r, state_nxt;
  logic [qwcg_pkg::NQ_W-1:0]     num_qubits_r;
  logic                          group_enable_r;
  logic [qwcg_pkg::GCNT_W-1:0]   total_r, total_nxt;
  qwcg_pkg::result_t             pend_r, pend_nxt;
  qwcg_pkg::result_t             out_res_r;
  logic                          out_valid_r;
  qwcg_pkg::token_t              chain [qwcg_pkg::MAX_GROUPS+1];
  qwcg_pkg::token_t              head_tok;
  qwcg_pkg::token_t              tok_last;
  logic [qwcg_pkg::MAX_GROUPS-1:0] tok_valids;
  logic [qwcg_pkg::WORD_W-1:0]   term;
  logic                          in_acc;
  logic                          emit_load;

  assign term     = in_tdata & qwcg_pkg::qubit_mask(num_qubits_r);
  assign in_acc   = in_tvalid && in_tready;
  assign chain[0] = head_tok;
  assign tok_last = chain[qwcg_pkg::MAX_GROUPS];

  for (genvar g = 0; g < qwcg_pkg::MAX_GROUPS; g++) begin : g_cell
    qwcg_cell u_cell (
      .clk          (clk),
      .rst_n        (rst_n),
      .cell_idx     (qwcg_pkg::GIDX_W'(g)),
      .group_total  (total_r),
      .group_enable (group_enable_r),
      .tok_in       (chain[g]),
      .tok_out      (chain[g+1])
    );
    assign tok_valids[g] = chain[g+1].valid;
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      qwcg_pkg::ST_IDLE: begin
        if (in_acc) begin
          if (in_tuser == qwcg_pkg::ACT_CLEAR || term == '0) begin
            state_nxt = qwcg_pkg::ST_EMIT;
          end else begin
            state_nxt = qwcg_pkg::ST_SCAN;
          end
        end
      end
      qwcg_pkg::ST_SCAN: begin
        if (tok_last.valid) begin
          state_nxt = qwcg_pkg::ST_EMIT;
        end
      end
      qwcg_pkg::ST_EMIT: begin
        if (!out_valid_r || out_tready) begin
          state_nxt = qwcg_pkg::ST_IDLE;
        end
      end
      default: state_nxt = qwcg_pkg::ST_IDLE;
    endcase
  end

  // Outputs of the controller.
  always_comb begin
    in_tready = 1'b0;
    emit_load = 1'b0;
    total_nxt = total_r;
    pend_nxt  = pend_r;
    head_tok  = '0;
    unique case (state_r)
      qwcg_pkg::ST_IDLE: begin
        in_tready = 1'b1;
        if (in_acc) begin
          pend_nxt = '0;
          if (in_tuser == qwcg_pkg::ACT_CLEAR) begin
            total_nxt = '0;
          end else if (term == '0) begin
            pend_nxt.is_id  = 1'b1;
            pend_nxt.groups = qwcg_pkg::OUT_CNT_W'(total_r);
          end else begin
            head_tok.valid = 1'b1;
            head_tok.term  = term;
          end
        end
      end
      qwcg_pkg::ST_SCAN: begin
        if (tok_last.valid) begin
          pend_nxt = '0;
          if (tok_last.found) begin
            total_nxt       = total_r + qwcg_pkg::GCNT_W'(tok_last.is_new);
            pend_nxt.gidx   = qwcg_pkg::OUT_IDX_W'(tok_last.idx);
            pend_nxt.is_new = tok_last.is_new;
            pend_nxt.basis  = tok_last.basis;
            pend_nxt.groups = qwcg_pkg::OUT_CNT_W'(total_nxt);
          end else begin
            pend_nxt.ovf    = 1'b1;
            pend_nxt.groups = qwcg_pkg::OUT_CNT_W'(total_r);
          end
        end
      end
      qwcg_pkg::ST_EMIT: begin
        emit_load = !out_valid_r || out_tready;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= qwcg_pkg::ST_IDLE;
      total_r        <= '0;
      out_valid_r    <= 1'b0;
      num_qubits_r   <= qwcg_pkg::NQ_W'(qwcg_pkg::MAX_QUBITS);
      group_enable_r <= 1'b1;
    end else begin
      state_r <= state_nxt;
      total_r <= total_nxt;
      if (emit_load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_wen) begin
        if (cfg_index == qwcg_pkg::CFG_NUM_QUBITS) begin
          num_qubits_r <= cfg_wdata;
        end else begin
          group_enable_r <= cfg_wdata[0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    pend_r <= pend_nxt;
    if (emit_load) begin
      out_res_r <= pend_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{qwcg_pkg::OUT_PAD_W{1'b0}}, out_res_r.groups, out_res_r.basis,
                       out_res_r.gidx};
  assign out_tuser  = {out_res_r.ovf, out_res_r.is_id, out_res_r.is_new};

  a_one_token: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(tok_valids))
    else $error("more than one request in the cell chain");

  a_total_bound: assert property (@(posedge clk) disable iff (!rst_n)
    int'(total_r) <= qwcg_pkg::MAX_GROUPS)
    else $error("group count above table size");

  a_idle_empty: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready |-> (tok_valids == '0))
    else $error("request accepted while the chain is busy");

  a_ovf_full: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_res_r.ovf) |-> (int'(out_res_r.groups) == qwcg_pkg::MAX_GROUPS))
    else $error("overflow reported with free groups");

  a_new_grows: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == qwcg_pkg::ST_SCAN && tok_last.valid && tok_last.is_new)
      |=> (total_r == $past(total_r) + 1'b1))
    else $error("new group did not raise the group count");

endmodule

// ----- design/qwcg_cell.sv -----
// One group cell: holds a group basis and tests, merges or stores the term passing through.
module qwcg_cell (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic [qwcg_pkg::GIDX_W-1:0] cell_idx,
  input  logic [qwcg_pkg::GCNT_W-1:0] group_total,
  input  logic                        group_enable,
  input  qwcg_pkg::token_t            tok_in,
  output qwcg_pkg::token_t            tok_out
);

  logic [qwcg_pkg::WORD_W-1:0] basis_r, basis_nxt;
  qwcg_pkg::token_t            tok_r, tok_nxt;
  logic                        in_use;
  logic                        hit;
  logic                        open;

  always_comb begin
    in_use    = qwcg_pkg::GCNT_W'(cell_idx) < group_total;
    hit       = tok_in.valid && !tok_in.found && in_use && group_enable
                && qwcg_pkg::agrees(tok_in.term, basis_r);
    open      = tok_in.valid && !tok_in.found && !hit
                && (qwcg_pkg::GCNT_W'(cell_idx) == group_total);
    basis_nxt = basis_r;
    tok_nxt   = tok_in;
    if (hit) begin
      basis_nxt     = qwcg_pkg::merge(basis_r, tok_in.term);
      tok_nxt.found = 1'b1;
      tok_nxt.idx   = cell_idx;
      tok_nxt.basis = basis_nxt;
    end else if (open) begin
      basis_nxt      = tok_in.term;
      tok_nxt.found  = 1'b1;
      tok_nxt.is_new = 1'b1;
      tok_nxt.idx    = cell_idx;
      tok_nxt.basis  = tok_in.term;
    end
  end

  always_ff @(posedge clk) begin
    basis_r <= basis_nxt;
    tok_r   <= tok_nxt;
    if (!rst_n) begin
      tok_r.valid <= 1'b0;
    end
  end

  assign tok_out = tok_r;

endmodule

// ----- sim/qwcg_grouping_checker.sv -----
// Checker that predicts every grouping result of the grouper and compares it on the out channel.
module qwcg_grouping_checker
  import qwcg_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  input  logic                   in_tready,
  input  logic [WORD_W-1:0]      in_tdata,   // [31:0] pauli_string
  input  logic                   in_tuser,   // [0] action
  input  logic                   out_tvalid,
  input  logic                   out_tready,
  input  logic [OUT_TDATA_W-1:0] out_tdata,  // [3:0] group_index, [35:4] merged_basis,
                                             // [40:36] groups_in_use
  input  logic [2:0]             out_tuser,  // [0] is_new_group, [1] is_identity, [2] overflow
  input  logic                   cfg_wen,
  input  logic                   cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_wdata,
  output int                     outstanding,
  output int                     failures
);

  logic [WORD_W-1:0] group_letters [MAX_GROUPS];
  int                groups_held = 0;
  logic [NQ_W-1:0]   qubits_in_use = NQ_W'(16);
  logic              merging_on = 1'b1;
  result_t           awaited_outcomes [$];
  int                error_tally = 0;

  function automatic logic letters_agree(input logic [WORD_W-1:0] term,
                                         input logic [WORD_W-1:0] basis);
    logic ok;
    ok = 1'b1;
    for (int q = 0; q < WORD_W / 2; q++) begin
      if (term[2*q +: 2] != 2'b00 && basis[2*q +: 2] != 2'b00 &&
          term[2*q +: 2] != basis[2*q +: 2]) begin
        ok = 1'b0;
      end
    end
    return ok;
  endfunction

  function automatic logic [WORD_W-1:0] fold_letters(input logic [WORD_W-1:0] basis,
                                                     input logic [WORD_W-1:0] term);
    logic [WORD_W-1:0] folded;
    folded = basis;
    for (int q = 0; q < WORD_W / 2; q++) begin
      if (term[2*q +: 2] != 2'b00) begin
        folded[2*q +: 2] = term[2*q +: 2];
      end
    end
    return folded;
  endfunction

  // Updates the held groups as the block should and returns the result it should give.
  function automatic result_t grouping_outcome(input logic action,
                                               input logic [WORD_W-1:0] pauli);
    result_t           res;
    logic [WORD_W-1:0] term;
    int                live_qubits;
    int                slot;
    res = '0;
    live_qubits = (int'(qubits_in_use) > MAX_QUBITS) ? MAX_QUBITS : int'(qubits_in_use);
    term = '0;
    for (int q = 0; q < live_qubits && q < WORD_W / 2; q++) begin
      term[2*q +: 2] = pauli[2*q +: 2];
    end
    if (action == ACT_CLEAR) begin
      groups_held = 0;
    end else if (term == '0) begin
      res.is_id = 1'b1;
    end else begin
      slot = -1;
      if (merging_on) begin
        for (int g = 0; g < groups_held && slot < 0; g++) begin
          if (letters_agree(term, group_letters[g])) begin
            slot = g;
          end
        end
      end
      if (slot < 0 && groups_held < MAX_GROUPS) begin
        slot = groups_held;
        group_letters[slot] = '0;
        groups_held++;
        res.is_new = 1'b1;
      end
      if (slot < 0) begin
        res.ovf = 1'b1;
      end else begin
        group_letters[slot] = fold_letters(group_letters[slot], term);
        res.gidx = OUT_IDX_W'(slot);
        res.basis = group_letters[slot];
      end
    end
    res.groups = OUT_CNT_W'(groups_held);
    return res;
  endfunction

  task automatic check_field(input string name, input logic [WORD_W-1:0] want,
                             input logic [WORD_W-1:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %h, got %h", $time, name, want, got);
      error_tally++;
    end
  endtask

  always @(posedge clk) begin : watch
    result_t seen;
    result_t want;
    if (!rst_n) begin
      awaited_outcomes.delete();
      groups_held = 0;
      qubits_in_use = NQ_W'(16);
      merging_on = 1'b1;
    end else begin
      if (cfg_wen) begin
        if (cfg_index == CFG_NUM_QUBITS) begin
          qubits_in_use = cfg_wdata[NQ_W-1:0];
        end else begin
          merging_on = cfg_wdata[0];
        end
      end
      if (out_tvalid && out_tready) begin
        seen.gidx   = out_tdata[OUT_IDX_W-1:0];
        seen.basis  = out_tdata[OUT_IDX_W +: WORD_W];
        seen.groups = out_tdata[OUT_IDX_W + WORD_W +: OUT_CNT_W];
        seen.is_new = out_tuser[0];
        seen.is_id  = out_tuser[1];
        seen.ovf    = out_tuser[2];
        if (awaited_outcomes.size() == 0) begin
          $display("%0t: result with no request outstanding, expected none, got %h/%b",
                   $time, out_tdata, out_tuser);
          error_tally++;
        end else begin
          want = awaited_outcomes.pop_front();
          check_field("group_index", WORD_W'(want.gidx), WORD_W'(seen.gidx));
          check_field("is_new_group", WORD_W'(want.is_new), WORD_W'(seen.is_new));
          check_field("is_identity", WORD_W'(want.is_id), WORD_W'(seen.is_id));
          check_field("overflow", WORD_W'(want.ovf), WORD_W'(seen.ovf));
          check_field("merged_basis", want.basis, seen.basis);
          check_field("groups_in_use", WORD_W'(want.groups), WORD_W'(seen.groups));
        end
      end
      if (in_tvalid && in_tready) begin
        awaited_outcomes = {awaited_outcomes, grouping_outcome(in_tuser, in_tdata)};
      end
    end
    outstanding <= awaited_outcomes.size();
    failures <= error_tally;
  end

endmodule

// ----- sim/qubitwise_commuting_grouper_tb.sv -----
// Testbench top for the qubit-wise commuting grouper: clock, reset, stimulus and verdict.
module qubitwise_commuting_grouper_tb;
  import qwcg_pkg::*;

  localparam int PHASES             = 8;
  localparam int REQUESTS_PER_PHASE = 200;
  localparam int WATCHDOG_LIMIT     = 2000;
  localparam int SETTLE_CYCLES      = 25;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [WORD_W-1:0]      in_tdata = '0;
  logic                   in_tuser = 1'b0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic [2:0]             out_tuser;
  logic                   cfg_wen = 1'b0;
  logic                   cfg_index = 1'b0;
  logic [CFG_DATA_W-1:0]  cfg_wdata = '0;
  int                     outstanding;
  int                     failures;
  int                     burst_left = 0;
  int                     idle_cycles = 0;
  int unsigned            beat = 0;
  logic [WORD_W-1:0]      themes [3];

  qubitwise_commuting_grouper DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_wen    (cfg_wen),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  qwcg_grouping_checker checker_i (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .cfg_wen     (cfg_wen),
    .cfg_index   (cfg_index),
    .cfg_wdata   (cfg_wdata),
    .outstanding (outstanding),
    .failures    (failures)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // The receiver cycles through free flow, light stalls, heavy stalls and a fixed stall pattern.
  always @(posedge clk) begin
    beat <= beat + 1;
    case (beat[9:8])
      2'd0: out_tready <= 1'b1;
      2'd1: out_tready <= ($urandom_range(0, 3) != 0);
      2'd2: out_tready <= ($urandom_range(0, 2) == 0);
      default: out_tready <= beat[3];
    endcase
  end

  always @(posedge clk) begin
    if (!rst_n || cfg_wen || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  task automatic send_request(input logic action, input logic [WORD_W-1:0] pauli);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 20);
      if (gap > 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 12);
    end
    burst_left--;
    in_tvalid <= 1'b1;
    in_tuser  <= action;
    in_tdata  <= pauli;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  task automatic drain_results();
    in_tvalid <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  task automatic configure(input logic [NQ_W-1:0] qubits, input logic merge_on);
    drain_results();
    cfg_wen   <= 1'b1;
    cfg_index <= CFG_NUM_QUBITS;
    cfg_wdata <= CFG_DATA_W'(qubits);
    @(posedge clk);
    cfg_index <= CFG_GROUP_ENABLE;
    cfg_wdata <= CFG_DATA_W'(merge_on);
    @(posedge clk);
    cfg_wen <= 1'b0;
  endtask

  // Most terms take a random subset of one theme's letters, so that they merge into groups.
  function automatic logic [WORD_W-1:0] random_term(input logic [WORD_W-1:0] theme);
    logic [WORD_W-1:0] word;
    logic [1:0]        letter;
    int                pick;
    pick = $urandom_range(0, 99);
    word = '0;
    if (pick < 55) begin
      for (int q = 0; q < WORD_W / 2; q++) begin
        if ($urandom_range(0, 2) == 0) word[2*q +: 2] = theme[2*q +: 2];
      end
    end else if (pick < 80) begin
      for (int q = 0; q < WORD_W / 2; q++) begin
        if ($urandom_range(0, 5) == 0) word[2*q +: 2] = 2'($urandom_range(1, 3));
      end
    end else if (pick < 95) begin
      word = $urandom();
    end else if (pick < 98) begin
      word = '0;
    end else begin
      letter = 2'($urandom_range(1, 3));
      word = {(WORD_W / 2){letter}};
    end
    return word;
  endfunction

  initial begin
    logic [NQ_W-1:0] nq_pick;
    logic            en_pick;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_request(ACT_PLACE, 32'h0000_0000);
    send_request(ACT_CLEAR, 32'hFFFF_FFFF);
    send_request(ACT_PLACE, 32'hFFFF_FFFF);
    send_request(ACT_PLACE, 32'h5555_5555);
    send_request(ACT_PLACE, 32'hAAAA_AAAA);
    send_request(ACT_PLACE, 32'h0000_0003);
    send_request(ACT_PLACE, 32'h0000_0004);
    // Narrowing the width with groups stored leaves their upper letters in place.
    configure(5'd2, 1'b1);
    send_request(ACT_PLACE, 32'hFFFF_FFF6);
    send_request(ACT_PLACE, 32'h0000_0002);
    configure(5'd0, 1'b0);
    send_request(ACT_PLACE, 32'hFFFF_FFFF);
    // The last of these finds the table full.
    configure(5'd31, 1'b0);
    for (int k = 0; k < 13; k++) begin
      send_request(ACT_PLACE, $urandom() | 32'h1);
    end
    send_request(ACT_CLEAR, $urandom());

    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0: configure(5'd16, 1'b1);
        1: configure(5'd1, 1'b1);
        2: configure(5'd31, 1'b1);
        3: configure(5'd8, 1'b0);
        default: begin
          nq_pick = ($urandom_range(0, 3) == 0) ? NQ_W'($urandom_range(0, 31))
                                                : NQ_W'($urandom_range(1, 16));
          en_pick = ($urandom_range(0, 4) != 0);
          configure(nq_pick, en_pick);
        end
      endcase
      for (int t = 0; t < 3; t++) begin
        themes[t] = $urandom();
      end
      if ($urandom_range(0, 1) == 0) send_request(ACT_CLEAR, $urandom());
      for (int k = 0; k < REQUESTS_PER_PHASE; k++) begin
        if ($urandom_range(0, 99) == 0) drain_results();
        if ($urandom_range(0, 24) == 0) begin
          send_request(ACT_CLEAR, $urandom());
        end else begin
          send_request(ACT_PLACE, random_term(themes[$urandom_range(0, 2)]));
        end
      end
    end

    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (failures == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
